// ===== src/brl_pkg.sv =====
// Shared types and constants for the line rasterizer.
// No dependencies; every other file in src depends on this package.
`default_nettype none

package brl_pkg;

  localparam int unsigned COORD_W    = 6;
  localparam int unsigned COLOUR_W   = 32;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ERR_W      = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 1'd1;

  typedef logic [COORD_W-1:0] coord_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // latch and order a new line
    logic step;  // emit the current point and advance
  } brl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic at_end;  // current point is the final one
  } brl_sts_t;

endpackage

`default_nettype wire

// ===== src/brl_if.sv =====
// Valid/ready channels for line commands and pixel writes.
// Depends on brl_pkg for field widths.
`default_nettype none

interface brl_line_if;
  logic                           valid;
  logic                           ready;
  logic [brl_pkg::COORD_W-1:0]    start_x;
  logic [brl_pkg::COORD_W-1:0]    start_y;
  logic [brl_pkg::COORD_W-1:0]    end_x;
  logic [brl_pkg::COORD_W-1:0]    end_y;
  logic [brl_pkg::COLOUR_W-1:0]   line_colour;

  modport source (output valid, start_x, start_y, end_x, end_y, line_colour, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, line_colour, output ready);
endinterface

interface brl_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [brl_pkg::COORD_W-1:0]    pixel_x;
  logic [brl_pkg::COORD_W-1:0]    pixel_y;
  logic [brl_pkg::COLOUR_W-1:0]   pixel_colour;
  logic                           in_bounds;
  logic                           last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_colour, in_bounds, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_colour, in_bounds, last_pixel,
                  output ready);
endinterface

`default_nettype wire

// ===== src/brl_ctrl.sv =====
// Sequencer for the line rasterizer: takes a command, walks it, meters output.
// Depends on brl_pkg.
`default_nettype none

module brl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              line_valid_i,
  output logic                   line_ready_o,
  output logic                   pix_valid_o,
  input  wire logic              pix_ready_i,
  output brl_pkg::brl_cmd_t      cmd_o,
  input  wire brl_pkg::brl_sts_t sts_i
);
  import brl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign line_ready_o = (state_q == ST_IDLE);
  assign out_free     = !out_valid_q || pix_ready_i;
  assign cmd_o.load   = line_valid_i && line_ready_o;
  assign cmd_o.step   = (state_q == ST_WALK) && out_free;
  assign pix_valid_o  = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.load) state_d = ST_WALK;
      ST_WALK: if (cmd_o.step && sts_i.at_end) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (pix_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/brl_dp.sv =====
// Datapath for the line rasterizer: clip registers, endpoint ordering,
// error accumulator walk and the pixel output register. Depends on brl_pkg.
`default_nettype none

module brl_dp #(
  parameter int unsigned MAX_DIM      = 64,
  parameter int unsigned COLOUR_BYTES = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [brl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [brl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic [brl_pkg::COORD_W-1:0]        start_x_i,
  input  wire logic [brl_pkg::COORD_W-1:0]        start_y_i,
  input  wire logic [brl_pkg::COORD_W-1:0]        end_x_i,
  input  wire logic [brl_pkg::COORD_W-1:0]        end_y_i,
  input  wire logic [brl_pkg::COLOUR_W-1:0]       line_colour_i,
  input  wire brl_pkg::brl_cmd_t                  cmd_i,
  output brl_pkg::brl_sts_t                       sts_o,
  output logic [brl_pkg::COORD_W-1:0]             pixel_x_o,
  output logic [brl_pkg::COORD_W-1:0]             pixel_y_o,
  output logic [brl_pkg::COLOUR_W-1:0]            pixel_colour_o,
  output logic                                    in_bounds_o,
  output logic                                    last_pixel_o
);
  import brl_pkg::*;

  localparam int unsigned CLIP_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned CBYTES_W = 8 * COLOUR_BYTES;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
  endfunction

  // Clip limits, stored already clamped to the canvas size.
  logic [CLIP_W-1:0] clip_w_q, clip_h_q;
  logic [CLIP_W-1:0] clip_wdata;

  assign clip_wdata = (cfg_wdata_i > CFG_DATA_W'(MAX_DIM)) ? CLIP_W'(MAX_DIM)
                                                            : CLIP_W'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_w_q <= CLIP_W'(MAX_DIM);
      clip_h_q <= CLIP_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CLIP_WIDTH:  clip_w_q <= clip_wdata;
        CFG_CLIP_HEIGHT: clip_h_q <= clip_wdata;
        default: ;
      endcase
    end
  end

  // Setup: swap axes for steep lines, then order along the major axis.
  logic   steep_c;
  coord_t a0_c, a1_c, b0_c, b1_c;
  coord_t maj0_c, maj1_c, min0_c, min1_c;

  always_comb begin
    steep_c = abs_diff(start_x_i, end_x_i) < abs_diff(start_y_i, end_y_i);
    a0_c = steep_c ? start_y_i : start_x_i;
    b0_c = steep_c ? start_x_i : start_y_i;
    a1_c = steep_c ? end_y_i   : end_x_i;
    b1_c = steep_c ? end_x_i   : end_y_i;
    if (a0_c > a1_c) begin
      maj0_c = a1_c; maj1_c = a0_c; min0_c = b1_c; min1_c = b0_c;
    end else begin
      maj0_c = a0_c; maj1_c = a1_c; min0_c = b0_c; min1_c = b1_c;
    end
  end

  // Walk registers.
  logic                    steep_q;
  logic                    up_q;
  coord_t                  major_q, end_q, minor_q, dmaj_q;
  logic [COORD_W:0]        dmin2_q;
  logic signed [ERR_W-1:0] err_q;
  logic [CBYTES_W-1:0]     colour_q;

  logic signed [ERR_W-1:0] err_sum;
  logic                    err_over;

  assign err_sum  = err_q + $signed(ERR_W'(dmin2_q));
  assign err_over = err_sum > $signed(ERR_W'(dmaj_q));
  assign sts_o.at_end = (major_q == end_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      steep_q  <= steep_c;
      up_q     <= min1_c > min0_c;
      major_q  <= maj0_c;
      end_q    <= maj1_c;
      minor_q  <= min0_c;
      dmaj_q   <= coord_t'(maj1_c - maj0_c);
      dmin2_q  <= {abs_diff(min1_c, min0_c), 1'b0};
      err_q    <= '0;
      colour_q <= line_colour_i[CBYTES_W-1:0];
    end else if (cmd_i.step) begin
      major_q <= coord_t'(major_q + 1'b1);
      if (err_over) begin
        minor_q <= up_q ? coord_t'(minor_q + 1'b1) : coord_t'(minor_q - 1'b1);
        err_q   <= err_sum - $signed(ERR_W'({dmaj_q, 1'b0}));
      end else begin
        err_q <= err_sum;
      end
    end
  end

  // Pixel output register.
  coord_t cur_x, cur_y;
  logic [CBYTES_W-1:0] out_colour_q;

  assign cur_x = steep_q ? minor_q : major_q;
  assign cur_y = steep_q ? major_q : minor_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pixel_x_o    <= cur_x;
      pixel_y_o    <= cur_y;
      out_colour_q <= colour_q;
      in_bounds_o  <= ({1'b0, cur_x} < CFG_DATA_W'(clip_w_q)) &&
                      ({1'b0, cur_y} < CFG_DATA_W'(clip_h_q));
      last_pixel_o <= sts_o.at_end;
    end
  end

  assign pixel_colour_o = COLOUR_W'(out_colour_q);

endmodule

`default_nettype wire

// ===== src/bresenham_line_rasterizer_top.sv =====
// Top level of the Bresenham line rasterizer.
// Depends on brl_pkg, brl_if (channels), brl_ctrl and brl_dp.
`default_nettype none

// Line rasterizer: each transfer on the line channel carries two endpoints and
// a colour, and the block answers with one pixel transfer per point of the
// line, both endpoints included, ordered so the major axis coordinate runs
// upward (x is the major axis unless the line is strictly steeper than 45
// degrees). Every pixel carries in_bounds, cleared when x or y reaches the
// clip width or height (clip values above MAX_DIM act as MAX_DIM, zero
// flags everything), and last_pixel on the final point. The block takes a
// command and orders its endpoints while idle, then steps the error accumulator
// one point per cycle while the output register is free or being taken, and
// holds while a pixel waits unaccepted; the next command is taken on the cycle
// right after the last step. A single command is in flight at a time; the last
// pixel may still wait in the output register while the next command is taken.
// Write the clip registers only while the block is idle; they take effect at
// once and there is no read-back.
module bresenham_line_rasterizer_top #(
  parameter int unsigned MAX_DIM      = 64,
  parameter int unsigned COLOUR_BYTES = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [brl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [brl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  brl_line_if.sink                            line_i,
  brl_pixel_if.source                         pixel_o
);
  import brl_pkg::*;

  // Command and status between sequencer and datapath.
  brl_cmd_t cmd;
  brl_sts_t sts;

  // Sequencer: owns the line handshake and the output valid flag.
  brl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_valid_i (line_i.valid),
    .line_ready_o (line_i.ready),
    .pix_valid_o  (pixel_o.valid),
    .pix_ready_i  (pixel_o.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Datapath: clip registers, endpoint ordering, walk and output register.
  brl_dp #(
    .MAX_DIM      (MAX_DIM),
    .COLOUR_BYTES (COLOUR_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_x_i      (line_i.start_x),
    .start_y_i      (line_i.start_y),
    .end_x_i        (line_i.end_x),
    .end_y_i        (line_i.end_y),
    .line_colour_i  (line_i.line_colour),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pixel_x_o      (pixel_o.pixel_x),
    .pixel_y_o      (pixel_o.pixel_y),
    .pixel_colour_o (pixel_o.pixel_colour),
    .in_bounds_o    (pixel_o.in_bounds),
    .last_pixel_o   (pixel_o.last_pixel)
  );

endmodule

`default_nettype wire
